// ===== rtl/core/hopf_oscillator_beat_clock_defines.svh =====
// ----------------------------------------------------------------------------
// hopf_oscillator_beat_clock_defines.svh
// Assertion macros shared by the beat clock RTL.
// ----------------------------------------------------------------------------
`ifndef HOPF_OSCILLATOR_BEAT_CLOCK_DEFINES_SVH
`define HOPF_OSCILLATOR_BEAT_CLOCK_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HOBC_ASSERT_NOW(LBL, CLK_SIG, RSTN_SIG, ANTE, CONS, MSG) \
    LBL: assert property (@(posedge CLK_SIG) disable iff (!RSTN_SIG) (ANTE) |-> (CONS)) \
        else $error(MSG);

// Next-cycle implication, disabled while reset is asserted.
`define HOBC_ASSERT_NEXT(LBL, CLK_SIG, RSTN_SIG, ANTE, CONS, MSG) \
    LBL: assert property (@(posedge CLK_SIG) disable iff (!RSTN_SIG) (ANTE) |=> (CONS)) \
        else $error(MSG);

`endif

// ===== rtl/core/hobc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hobc_pkg
// Widths, codes and constants for the Hopf oscillator beat clock.
// ----------------------------------------------------------------------------
package hobc_pkg;

    // item and register field widths
    localparam int POS_W      = 20;   // Q3.16 signed
    localparam int FREQ_W     = 24;   // Q7.16 signed
    localparam int GAIN_W     = 16;   // Q8.8 unsigned
    localparam int RAD_W      = 18;   // Q2.16 unsigned
    localparam int STEP_W     = 24;   // Q0.24 unsigned
    localparam int MAXF_W     = 23;   // Q7.16 unsigned
    localparam int BEAT_W     = 32;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // shared multiplier: signed A x signed B
    localparam int MUL_A_W    = 36;
    localparam int MUL_B_W    = 25;
    localparam int MUL_P_W    = MUL_A_W + MUL_B_W;

    // 2*pi (pi = 3.1415) in Q.24
    localparam int TWO_PI_W   = 27;
    localparam logic [TWO_PI_W-1:0] TWO_PI_Q24 = 27'd105411248;

    // item kinds
    localparam logic KIND_TICK     = 1'b0;
    localparam logic KIND_SET_FREQ = 1'b1;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN     = 3'd0,
        CFG_RADIUS   = 3'd1,
        CFG_STEP     = 3'd2,
        CFG_MAX_FREQ = 3'd3
    } cfg_idx_t;

    // sequencer states, at most one shared multiply issued per state
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_XX,
        ST_YY,
        ST_D,
        ST_GH,
        ST_GL,
        ST_E,
        ST_EX,
        ST_WY,
        ST_DX,
        ST_WX,
        ST_DY,
        ST_NX,
        ST_NY,
        ST_BH,
        ST_BL,
        ST_FIN
    } seq_state_t;

endpackage

// ===== rtl/core/hobc_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hobc_if
// Valid/ready channels of the beat clock: command items, result items and
// configuration writes.
// ----------------------------------------------------------------------------
interface hobc_cmd_if;
    import hobc_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     kind;
    logic signed [FREQ_W-1:0] freq_value;

    modport source (output valid, output kind, output freq_value, input ready);
    modport sink   (input valid, input kind, input freq_value, output ready);
endinterface

interface hobc_res_if;
    import hobc_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic [BEAT_W-1:0]       beat_count;
    logic                    beat_pulse;

    modport source (output valid, output pos_x, output pos_y, output beat_count,
                    output beat_pulse, input ready);
    modport sink   (input valid, input pos_x, input pos_y, input beat_count,
                    input beat_pulse, output ready);
endinterface

interface hobc_cfg_if;
    import hobc_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/hobc_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hobc_mul
// Shared signed multiplier with a registered product, one result per cycle.
// ----------------------------------------------------------------------------
module hobc_mul (
    input  logic                                 clk,
    input  logic signed [hobc_pkg::MUL_A_W-1:0]  a,
    input  logic signed [hobc_pkg::MUL_B_W-1:0]  b,
    output logic signed [hobc_pkg::MUL_P_W-1:0]  prod
);
    import hobc_pkg::*;

    logic signed [MUL_P_W-1:0] prod_reg;
    logic signed [MUL_P_W-1:0] prod_next;

    always_comb
    begin
        prod_next = MUL_P_W'(a) * MUL_P_W'(b);
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

// ===== rtl/core/hopf_oscillator_beat_clock.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hopf_oscillator_beat_clock
// Beat clock driven by a Hopf oscillator, one explicit Euler step per tick.
// ----------------------------------------------------------------------------
// A tick item (kind 0) advances the oscillator state (x, y) by one Euler step
// of size time_step, pulling it toward the circle of squared radius
// target_radius_sq at rate gain and rotating it at 2*pi*freq Hz, and returns
// one result item: the new x and y (Q3.16, saturated), the beat count and a
// beat pulse. A beat fires when ticks_since_beat * time_step * freq exceeds
// 1.0. A set-frequency item (kind 1) returns nothing; it takes effect only if
// the value is below the frequency ceiling register, and a negative accepted
// value halts the block for good (every later item is swallowed without a
// result). All multiplies run on a single 36x25 signed multiplier with a
// registered product. A 16-state sequence issues fourteen of them, one per
// cycle, then runs the beat test and hands off the result: a tick item holds
// ready low from its accepting edge until that hand-off (longer if the
// result side stalls it), so a new tick waits for the sequence to finish;
// a set-frequency item, or any item while halted, leaves ready high.
// The result register sits apart from the sequencer, so a finished result
// can wait while the block takes the next item. Configuration writes are
// always ready and must only be issued while the block is idle.
// ----------------------------------------------------------------------------
`include "hopf_oscillator_beat_clock_defines.svh"

module hopf_oscillator_beat_clock (
    input  logic      clk,
    input  logic      rst_n,
    hobc_cmd_if.sink  cmd,
    hobc_res_if.source result,
    hobc_cfg_if.sink  cfg
);
    import hobc_pkg::*;

    // position sum width: x (20b) plus a step of up to 37 bits
    localparam int POS_SUM_W = 38;
    localparam int ACC_W     = 64;
    localparam int E_W       = 33;
    localparam int DXS_W     = MUL_A_W;
    localparam int Q_W       = 47;
    localparam int BSUM_W    = 58;
    localparam logic [BSUM_W-1:0] BEAT_ONE = BSUM_W'(65536);

    // ------------------------------------------------------------------
    // state
    // ------------------------------------------------------------------
    seq_state_t state_reg, state_next;

    logic [GAIN_W-1:0]  gain_reg,  gain_next;
    logic [RAD_W-1:0]   trs_reg,   trs_next;
    logic [STEP_W-1:0]  ts_reg,    ts_next;
    logic [MAXF_W-1:0]  maxf_reg,  maxf_next;

    logic signed [POS_W-1:0]  x_reg, x_next;
    logic signed [POS_W-1:0]  y_reg, y_next;
    logic signed [FREQ_W-1:0] freq_reg, freq_next;
    logic [BEAT_W-1:0]        beats_reg, beats_next;
    logic [BEAT_W-1:0]        ticks_reg, ticks_next;
    logic                     halted_reg, halted_next;
    logic                     pulse_reg, pulse_next;

    // datapath scratch (no reset)
    logic signed [ACC_W-1:0]    acc_reg, acc_next;
    logic signed [E_W-1:0]      e_reg, e_next;
    logic signed [TWO_PI_W-1:0] w_reg, w_next;
    logic [Q_W-1:0]             q_reg, q_next;
    logic signed [DXS_W-1:0]    dxs_reg, dxs_next;

    // result register
    logic                    out_valid_reg, out_valid_next;
    logic signed [POS_W-1:0] out_x_reg, out_x_next;
    logic signed [POS_W-1:0] out_y_reg, out_y_next;
    logic [BEAT_W-1:0]       out_beats_reg, out_beats_next;
    logic                    out_pulse_reg, out_pulse_next;

    // shared multiplier
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] prod;

    // helpers
    logic signed [ACC_W-1:0]     prod_ext;
    logic signed [ACC_W-1:0]     e_sum;
    logic signed [POS_SUM_W-1:0] step_ext;
    logic signed [POS_SUM_W-1:0] x_sum;
    logic signed [POS_SUM_W-1:0] y_sum;
    logic [BSUM_W-1:0]           beat_sum;
    logic                        beat_lo_nz;
    logic                        beat_fire;
    logic                        cmd_take;
    logic                        freq_ok;
    logic                        out_free;

    function automatic logic signed [POS_W-1:0] sat_pos(
        input logic signed [POS_SUM_W-1:0] v
    );
        logic [POS_SUM_W-POS_W:0] top;
        logic signed [POS_W-1:0]  r;
        top = v[POS_SUM_W-1:POS_W-1];
        if ((top == '0) || (top == '1))
        begin
            r = v[POS_W-1:0];
        end
        else if (v[POS_SUM_W-1])
        begin
            r = {1'b1, {(POS_W-1){1'b0}}};
        end
        else
        begin
            r = {1'b0, {(POS_W-1){1'b1}}};
        end
        return r;
    endfunction

    hobc_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    assign cmd.ready = (state_reg == ST_IDLE);
    assign cfg.ready = 1'b1;
    assign cmd_take  = cmd.valid && (state_reg == ST_IDLE);
    assign out_free  = !out_valid_reg || result.ready;

    assign result.valid      = out_valid_reg;
    assign result.pos_x      = out_x_reg;
    assign result.pos_y      = out_y_reg;
    assign result.beat_count = out_beats_reg;
    assign result.beat_pulse = out_pulse_reg;

    // product helpers; the Q.24 step is prod >>> 24 (floor)
    assign prod_ext   = ACC_W'(prod);
    assign e_sum      = acc_reg + prod_ext;
    assign step_ext   = POS_SUM_W'($signed(prod[MUL_P_W-1:24]));
    assign x_sum      = POS_SUM_W'(x_reg) + step_ext;
    assign y_sum      = POS_SUM_W'(y_reg) + step_ext;
    assign freq_ok    = cmd.freq_value < $signed({1'b0, maxf_reg});

    // t*q > 2^40 with q = qh*2^24 + ql:
    // (t*qh + (t*ql >> 24)) > 2^16, or == 2^16 with low bits of t*ql nonzero
    assign beat_sum   = acc_reg[BSUM_W-1:0] + {24'd0, prod[BSUM_W-1:24]};
    assign beat_lo_nz = |prod[23:0];
    assign beat_fire  = (beat_sum > BEAT_ONE) || ((beat_sum == BEAT_ONE) && beat_lo_nz);

    // ------------------------------------------------------------------
    // sequencer: next state, datapath and operand selection
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        gain_next      = gain_reg;
        trs_next       = trs_reg;
        ts_next        = ts_reg;
        maxf_next      = maxf_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        freq_next      = freq_reg;
        beats_next     = beats_reg;
        ticks_next     = ticks_reg;
        halted_next    = halted_reg;
        pulse_next     = pulse_reg;
        acc_next       = acc_reg;
        e_next         = e_reg;
        w_next         = w_reg;
        q_next         = q_reg;
        dxs_next       = dxs_reg;
        out_valid_next = out_valid_reg && !result.ready;
        out_x_next     = out_x_reg;
        out_y_next     = out_y_reg;
        out_beats_next = out_beats_reg;
        out_pulse_next = out_pulse_reg;
        mul_a          = MUL_A_W'(x_reg);
        mul_b          = MUL_B_W'(x_reg);

        // config writes
        if (cfg.valid)
        begin
            case (cfg.index)
                CFG_GAIN:     gain_next = cfg.data[GAIN_W-1:0];
                CFG_RADIUS:   trs_next  = cfg.data[RAD_W-1:0];
                CFG_STEP:     ts_next   = cfg.data[STEP_W-1:0];
                CFG_MAX_FREQ: maxf_next = cfg.data[MAXF_W-1:0];
                default:      ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_take && !halted_reg)
                begin
                    if (cmd.kind == KIND_SET_FREQ)
                    begin
                        if (freq_ok)
                        begin
                            freq_next   = cmd.freq_value;
                            halted_next = cmd.freq_value[FREQ_W-1];
                        end
                    end
                    else
                    begin
                        if (ticks_reg != '1)
                        begin
                            ticks_next = ticks_reg + 1'b1;
                        end
                        state_next = ST_XX;
                    end
                end
            end
            ST_XX:
            begin
                // issue x*x (default operands)
                state_next = ST_YY;
            end
            ST_YY:
            begin
                mul_a      = MUL_A_W'(y_reg);
                mul_b      = MUL_B_W'(y_reg);
                acc_next   = $signed(ACC_W'({trs_reg, 16'd0})) - prod_ext;
                state_next = ST_D;
            end
            ST_D:
            begin
                // w = 2*pi*f; acc becomes d
                mul_a      = $signed(MUL_A_W'(TWO_PI_Q24));
                mul_b      = MUL_B_W'(freq_reg);
                acc_next   = acc_reg - prod_ext;
                state_next = ST_GH;
            end
            ST_GH:
            begin
                // gain * (d >>> 16)
                mul_a      = MUL_A_W'($signed(acc_reg[40:16]));
                mul_b      = $signed(MUL_B_W'(gain_reg));
                w_next     = prod[50:24];
                state_next = ST_GL;
            end
            ST_GL:
            begin
                // gain * d[15:0]
                mul_a      = $signed(MUL_A_W'(acc_reg[15:0]));
                mul_b      = $signed(MUL_B_W'(gain_reg));
                acc_next   = prod_ext <<< 16;
                state_next = ST_E;
            end
            ST_E:
            begin
                // start beat threshold product time_step * freq
                mul_a      = $signed(MUL_A_W'(ts_reg));
                mul_b      = MUL_B_W'(freq_reg);
                e_next     = e_sum[56:24];
                state_next = ST_EX;
            end
            ST_EX:
            begin
                mul_a      = MUL_A_W'(e_reg);
                mul_b      = MUL_B_W'(x_reg);
                q_next     = prod[Q_W-1:0];
                state_next = ST_WY;
            end
            ST_WY:
            begin
                mul_a      = MUL_A_W'(w_reg);
                mul_b      = MUL_B_W'(y_reg);
                acc_next   = prod_ext;
                state_next = ST_DX;
            end
            ST_DX:
            begin
                mul_a      = MUL_A_W'(e_reg);
                mul_b      = MUL_B_W'(y_reg);
                acc_next   = acc_reg - prod_ext;
                state_next = ST_WX;
            end
            ST_WX:
            begin
                mul_a      = MUL_A_W'(w_reg);
                mul_b      = MUL_B_W'(x_reg);
                dxs_next   = acc_reg[51:16];
                acc_next   = prod_ext;
                state_next = ST_DY;
            end
            ST_DY:
            begin
                mul_a      = dxs_reg;
                mul_b      = $signed(MUL_B_W'(ts_reg));
                acc_next   = acc_reg + prod_ext;
                state_next = ST_NX;
            end
            ST_NX:
            begin
                mul_a      = acc_reg[51:16];
                mul_b      = $signed(MUL_B_W'(ts_reg));
                x_next     = sat_pos(x_sum);
                state_next = ST_NY;
            end
            ST_NY:
            begin
                // ticks * (q >> 24)
                mul_a      = $signed(MUL_A_W'(ticks_reg));
                mul_b      = $signed(MUL_B_W'(q_reg[Q_W-1:24]));
                y_next     = sat_pos(y_sum);
                state_next = ST_BH;
            end
            ST_BH:
            begin
                // ticks * q[23:0]
                mul_a      = $signed(MUL_A_W'(ticks_reg));
                mul_b      = $signed(MUL_B_W'(q_reg[23:0]));
                acc_next   = prod_ext;
                state_next = ST_BL;
            end
            ST_BL:
            begin
                pulse_next = beat_fire;
                if (beat_fire)
                begin
                    beats_next = beats_reg + 1'b1;
                    ticks_next = '0;
                end
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_x_next     = x_reg;
                    out_y_next     = y_reg;
                    out_beats_next = beats_reg;
                    out_pulse_next = pulse_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            gain_reg      <= GAIN_W'(3840);
            trs_reg       <= RAD_W'(65536);
            ts_reg        <= STEP_W'(16777);
            maxf_reg      <= MAXF_W'(655360);
            x_reg         <= '0;
            y_reg         <= POS_W'(65536);
            freq_reg      <= FREQ_W'(32768);
            beats_reg     <= '0;
            ticks_reg     <= '0;
            halted_reg    <= 1'b0;
            pulse_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            gain_reg      <= gain_next;
            trs_reg       <= trs_next;
            ts_reg        <= ts_next;
            maxf_reg      <= maxf_next;
            x_reg         <= x_next;
            y_reg         <= y_next;
            freq_reg      <= freq_next;
            beats_reg     <= beats_next;
            ticks_reg     <= ticks_next;
            halted_reg    <= halted_next;
            pulse_reg     <= pulse_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath and result payload
    always_ff @(posedge clk)
    begin
        acc_reg       <= acc_next;
        e_reg         <= e_next;
        w_reg         <= w_next;
        q_reg         <= q_next;
        dxs_reg       <= dxs_next;
        out_x_reg     <= out_x_next;
        out_y_reg     <= out_y_next;
        out_beats_reg <= out_beats_next;
        out_pulse_reg <= out_pulse_next;
    end

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `HOBC_ASSERT_NEXT(a_halt_sticky, clk, rst_n, halted_reg, halted_reg, "halt flag cleared")
    `HOBC_ASSERT_NOW(a_freq_nonneg, clk, rst_n, !halted_reg, !freq_reg[FREQ_W-1], "negative freq")
    `HOBC_ASSERT_NOW(a_pulse_ticks, clk, rst_n, state_reg == ST_FIN,
        pulse_reg == (ticks_reg == '0), "beat pulse and tick count disagree")
    `HOBC_ASSERT_NEXT(a_tick_start, clk, rst_n,
        cmd.valid && cmd.ready && !halted_reg && (cmd.kind == KIND_TICK),
        state_reg == ST_XX, "tick item did not start a step")
    `HOBC_ASSERT_NOW(a_res_load, clk, rst_n, $rose(out_valid_reg),
        $past(state_reg == ST_FIN), "result appeared outside hand-off")

endmodule

// ===== tb/tb_hopf_oscillator_beat_clock.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hopf_oscillator_beat_clock
// Self-checking bench for the Hopf oscillator beat clock. A scoreboard class
// tracks the oscillator, frequency and beat state in 64-bit fixed point and
// matches every result item field by field. Stimulus is a short directed
// pass, then random phases with different register settings, ragged
// command bursts and a stalling result sink, and a final halt.
// ----------------------------------------------------------------------------
module tb_hopf_oscillator_beat_clock;
    import hobc_pkg::*;

    // run sizing
    localparam int LIMIT        = 400000;  // cycles before the run is declared hung
    localparam int SETTLE       = 24;      // margin for a trailing tick to finish
    localparam int DRAIN_LIMIT  = 4000;    // wait bound for outstanding results
    localparam int RANDOM_ITEMS = 1850;
    localparam int PHASES       = 7;

    // fixed-point limits of the oscillator state and the beat threshold (1.0 in Q.40)
    localparam longint POS_HI   = (longint'(1) <<< (POS_W - 1)) - 1;
    localparam longint POS_LO   = -(longint'(1) <<< (POS_W - 1));
    localparam longint BEAT_ONE = longint'(1) <<< 40;

    // one expected result item
    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic [BEAT_W-1:0]       count;
        logic                    pulse;
    } osc_sample_t;

    // result sink behavior, switched after a random run of cycles
    typedef enum int {SINK_OPEN, SINK_COIN, SINK_CHOKE} sink_mode_t;

    // ------------------------------------------------------------------------
    // Scoreboard: register copy, oscillator state and the queue of samples due
    // ------------------------------------------------------------------------
    class oscillator_tracker;
        logic [GAIN_W-1:0] gain_q8;
        logic [RAD_W-1:0]  radius_sq;
        logic [STEP_W-1:0] step_dt;
        logic [MAXF_W-1:0] freq_cap;
        longint            pos_x;
        longint            pos_y;
        longint            freq_hz;
        logic [BEAT_W-1:0] beat_total;
        logic [BEAT_W-1:0] ticks_idle;
        bit                stopped;
        osc_sample_t       due[$];
        int                errors;

        function new();
            gain_q8    = 16'd3840;
            radius_sq  = 18'd65536;
            step_dt    = 24'd16777;
            freq_cap   = 23'd655360;
            pos_x      = 0;
            pos_y      = 65536;
            freq_hz    = 32768;
            beat_total = '0;
            ticks_idle = '0;
            stopped    = 1'b0;
            errors     = 0;
        endfunction

        task report(string msg);
            errors++;
            $display("[%0t] MISMATCH %s", $time, msg);
        endtask

        function void set_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_GAIN:     gain_q8   = data[GAIN_W-1:0];
                CFG_RADIUS:   radius_sq = data[RAD_W-1:0];
                CFG_STEP:     step_dt   = data[STEP_W-1:0];
                CFG_MAX_FREQ: freq_cap  = data[MAXF_W-1:0];
                default: ;
            endcase
        endfunction

        function longint clamp_pos(longint v);
            if (v > POS_HI)
                return POS_HI;
            if (v < POS_LO)
                return POS_LO;
            return v;
        endfunction

        // one Euler step plus the beat test; all shifts are floors (>>> on signed)
        function void euler_tick();
            longint      r2, d, e, w, dx, dy, span, lim;
            osc_sample_t s;
            s.pulse = 1'b0;
            if (ticks_idle != '1)
                ticks_idle++;
            if (freq_hz != 0) begin
                span = longint'(ticks_idle) * longint'(step_dt);
                lim  = BEAT_ONE / freq_hz;
                if (span > lim) begin
                    beat_total++;
                    ticks_idle = '0;
                    s.pulse    = 1'b1;
                end
            end
            r2 = pos_x * pos_x + pos_y * pos_y;
            d  = (longint'(radius_sq) <<< 16) - r2;
            e  = (longint'(gain_q8) * d) >>> 24;
            w  = (longint'(TWO_PI_Q24) * freq_hz) >>> 24;
            dx = e * pos_x - w * pos_y;
            dy = e * pos_y + w * pos_x;
            dx = ((dx >>> 16) * longint'(step_dt)) >>> 24;
            dy = ((dy >>> 16) * longint'(step_dt)) >>> 24;
            pos_x = clamp_pos(pos_x + dx);
            pos_y = clamp_pos(pos_y + dy);
            s.x     = pos_x[POS_W-1:0];
            s.y     = pos_y[POS_W-1:0];
            s.count = beat_total;
            due.push_back(s);
        endfunction

        function void take_command(logic kind, logic signed [FREQ_W-1:0] fv);
            longint v;
            if (stopped)
                return;
            v = fv;
            if (kind == KIND_SET_FREQ) begin
                if (v < longint'(freq_cap)) begin
                    freq_hz = v;
                    if (v < 0)
                        stopped = 1'b1;
                end
            end else begin
                euler_tick();
            end
        endfunction

        task match_result(logic signed [POS_W-1:0] x, logic signed [POS_W-1:0] y,
                          logic [BEAT_W-1:0] cnt, logic pulse);
            osc_sample_t s;
            if (due.size() == 0) begin
                report($sformatf("unexpected result x=%0d y=%0d count=%0d pulse=%0b",
                                 x, y, cnt, pulse));
                return;
            end
            s = due.pop_front();
            if (x !== s.x)
                report($sformatf("pos_x got %0d want %0d", x, s.x));
            if (y !== s.y)
                report($sformatf("pos_y got %0d want %0d", y, s.y));
            if (cnt !== s.count)
                report($sformatf("beat_count got %0d want %0d", cnt, s.count));
            if (pulse !== s.pulse)
                report($sformatf("beat_pulse got %0b want %0b", pulse, s.pulse));
        endtask

        task flag_leftovers();
            if (due.size() != 0)
                report($sformatf("%0d expected results never arrived", due.size()));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset, channels and the block under test
    // ------------------------------------------------------------------------
    logic clk = 1'b0;
    logic rst_n;

    hobc_cmd_if cmd_ch ();
    hobc_res_if res_ch ();
    hobc_cfg_if cfg_ch ();

    hopf_oscillator_beat_clock dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd_ch),
        .result (res_ch),
        .cfg    (cfg_ch)
    );

    oscillator_tracker board;

    int         cycle_count;
    int         burst_left;
    bit         steady;       // phase with no sender gaps
    sink_mode_t sink_mode;
    int         mode_left;
    int         hold_left;

    always #1 clk = ~clk;

    // Result monitor: sampled at the rising edge, where the handshake completes.
    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready)
            board.match_result(res_ch.pos_x, res_ch.pos_y, res_ch.beat_count,
                               res_ch.beat_pulse);
    end

    // Result sink: runs of always-ready, coin-flip readiness and long stalls.
    // The mode changes on its own schedule, so stalls land on every phase of
    // the tick sequence and on the parked result register.
    always @(negedge clk)
    begin
        if (mode_left == 0) begin
            sink_mode = sink_mode_t'($urandom_range(0, 2));
            mode_left = $urandom_range(20, 200);
        end else begin
            mode_left--;
        end
        if (hold_left != 0) begin
            hold_left--;
            res_ch.ready <= 1'b0;
        end else begin
            case (sink_mode)
                SINK_OPEN: res_ch.ready <= 1'b1;
                SINK_COIN: res_ch.ready <= 1'($urandom_range(0, 1));
                default: begin
                    if ($urandom_range(0, 3) == 0) begin
                        hold_left = $urandom_range(1, 11);
                        res_ch.ready <= 1'b0;
                    end else begin
                        res_ch.ready <= 1'b1;
                    end
                end
            endcase
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("end of test: mismatches");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Drivers. All called at a falling edge and return at a falling edge.
    // ------------------------------------------------------------------------

    // Offer one command item and hold it until the block takes it. valid is
    // left high on return so back-to-back items keep it asserted.
    task automatic push_item(input logic k, input logic signed [FREQ_W-1:0] fv);
        cmd_ch.valid      <= 1'b1;
        cmd_ch.kind       <= k;
        cmd_ch.freq_value <= fv;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        board.take_command(k, fv);
        @(negedge clk);
    endtask

    // Sender pacing: bursts of random length with idle gaps in between.
    task automatic pace();
        int gap;
        if (steady)
            return;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap != 0) begin
                cmd_ch.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
    endtask

    // Stop sending, wait for every expected result, then let a set-frequency
    // item that trails the last tick finish before the block is touched.
    task automatic settle();
        int waited = 0;
        cmd_ch.valid <= 1'b0;
        while (board.due.size() != 0 && waited < DRAIN_LIMIT) begin
            @(negedge clk);
            waited++;
        end
        repeat (SETTLE) @(negedge clk);
    endtask

    // One register write; bits above the register width carry random junk,
    // which the block must drop.
    task automatic put_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value,
                           input int w);
        logic [CFG_DATA_W-1:0] keep;
        logic [CFG_DATA_W-1:0] word;
        keep = (24'h1 << w) - 24'h1;
        word = (CFG_DATA_W'($urandom()) & ~keep) | (value & keep);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= word;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        board.set_reg(idx, word);
        @(negedge clk);
    endtask

    task automatic program_regs(input logic [GAIN_W-1:0] g, input logic [RAD_W-1:0] r,
                                input logic [STEP_W-1:0] st, input logic [MAXF_W-1:0] m);
        settle();
        put_reg(CFG_GAIN, CFG_DATA_W'(g), GAIN_W);
        put_reg(CFG_RADIUS, CFG_DATA_W'(r), RAD_W);
        put_reg(CFG_STEP, CFG_DATA_W'(st), STEP_W);
        put_reg(CFG_MAX_FREQ, CFG_DATA_W'(m), MAXF_W);
        cfg_ch.valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        logic [MAXF_W-1:0]        cap;
        logic signed [FREQ_W-1:0] fv;
        int                       per_phase;

        board = new();
        rst_n             = 1'b0;
        cmd_ch.valid      = 1'b0;
        cmd_ch.kind       = KIND_TICK;
        cmd_ch.freq_value = '0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.index      = CFG_GAIN;
        cfg_ch.data       = '0;
        res_ch.ready      = 1'b0;
        sink_mode         = SINK_OPEN;
        mode_left         = 0;
        hold_left         = 0;
        burst_left        = 0;
        steady            = 1'b0;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // --- directed: reset registers ---
        // Just below the frequency bound is taken, at the bound and the top
        // positive value are refused. Ticks carry junk in freq_value, which
        // they must ignore. Zero frequency stops rotation and beats.
        push_item(KIND_SET_FREQ, 24'sd655359);
        push_item(KIND_TICK, 24'sd0);
        push_item(KIND_TICK, -24'sd8388608);
        push_item(KIND_SET_FREQ, 24'sd655360);
        push_item(KIND_SET_FREQ, 24'sd8388607);
        push_item(KIND_TICK, 24'sd8388607);
        push_item(KIND_SET_FREQ, 24'sd0);
        push_item(KIND_TICK, 24'sd0);
        push_item(KIND_TICK, 24'sd0);

        // --- directed: every register at its top; state runs into saturation ---
        program_regs(16'hFFFF, 18'h3FFFF, 24'hFFFFFF, 23'h7FFFFF);
        push_item(KIND_SET_FREQ, 24'sd8388606);
        repeat (3) push_item(KIND_TICK, FREQ_W'($urandom()));

        // --- directed: every register at zero; zero step freezes the state,
        // and a zero bound refuses every non-negative frequency ---
        program_regs('0, '0, '0, '0);
        push_item(KIND_SET_FREQ, 24'sd1);
        push_item(KIND_TICK, FREQ_W'($urandom()));
        push_item(KIND_TICK, FREQ_W'($urandom()));
        push_item(KIND_SET_FREQ, 24'sd0);

        // --- directed: ordinary settings, 5 Hz at a 10 ms step ---
        program_regs(16'd3840, 18'd65536, 24'd167772, 23'd655360);
        push_item(KIND_SET_FREQ, 24'sd327680);
        repeat (6) push_item(KIND_TICK, FREQ_W'($urandom()));

        // --- random phases, each under its own register setting ---
        per_phase = RANDOM_ITEMS / PHASES;
        for (int p = 0; p < PHASES; p++) begin
            if (p == 0)
                cap = 23'h7FFFFF;
            else if (p == 1)
                cap = '0;
            else if (p == PHASES - 1)
                cap = 23'd655360;
            else
                cap = MAXF_W'($urandom_range(1, 8388607));

            if (p == 0)
                program_regs(16'hFFFF, 18'h3FFFF, 24'hFFFFFF, cap);
            else if (p == 1)
                program_regs('0, '0, 24'd1, cap);
            else if (p == PHASES - 1)
                program_regs(16'd3840, 18'd65536, 24'd16777, cap);
            else
                program_regs(GAIN_W'($urandom_range(0, 8191)),
                             RAD_W'($urandom_range(0, 262143)),
                             STEP_W'($urandom_range(20000, 400000)), cap);

            // every third phase streams with no sender gaps
            steady = (p % 3 == 2);
            for (int i = 0; i < per_phase; i++) begin
                pace();
                if ($urandom_range(0, 4) != 0) begin
                    push_item(KIND_TICK, FREQ_W'($urandom()));
                end else if (cap != 0 && $urandom_range(0, 3) != 0) begin
                    // accepted value; a third of them slow enough for long beat gaps
                    if ($urandom_range(0, 2) == 0 && cap > 131072)
                        fv = FREQ_W'($urandom_range(0, 131071));
                    else
                        fv = FREQ_W'($urandom_range(0, cap - 1));
                    push_item(KIND_SET_FREQ, fv);
                end else begin
                    // any non-negative value; refused when at or above the bound
                    push_item(KIND_SET_FREQ, FREQ_W'($urandom_range(0, 8388607)));
                end
            end
        end

        // --- halt: a negative frequency is always under the bound and stops
        // the block; everything after it is swallowed without a result ---
        steady = 1'b0;
        fv = -FREQ_W'($urandom_range(1, 8388608));
        push_item(KIND_SET_FREQ, fv);
        for (int i = 0; i < 10; i++) begin
            pace();
            push_item(1'($urandom_range(0, 1)), FREQ_W'($urandom()));
        end

        settle();
        board.flag_leftovers();
        if (board.errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
